/* rtl/blp_pkg.sv */
// Shared field widths, mode codes and level-cell types for the trie route store.
package blp_pkg;

    // Fixed field widths of the item and result beats
    localparam int HOP_BITS        = 32;
    localparam int PORT_FIELD_BITS = 8;
    localparam int LEN_FIELD_BITS  = 6;

    // Item mode codes
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    // What one level cell holds and hands to its neighbor
    typedef struct packed {
        logic addr_bit;
        logic live;
    } t_lvl;

    // Control that the walk sequencer sends to every level cell
    typedef struct packed {
        logic load;
        logic shift;
        logic lookup;
    } t_lvl_ctl;

endpackage

/* rtl/blp_level_cell.sv */
// One trie level cell: holds one address bit and its in-prefix flag, shifts toward level 0.
module blp_level_cell #(
    parameter int IDX      = 0,
    parameter int LEN_BITS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  blp_pkg::t_lvl_ctl    i_ctl,
    input  logic                 i_load_bit,
    input  logic [LEN_BITS-1:0]  i_load_len,
    input  blp_pkg::t_lvl        i_next,
    output blp_pkg::t_lvl        o_lvl
);
    import blp_pkg::*;

    t_lvl r_lvl;
    t_lvl n_lvl;

    // Load this level's bit on a new beat, else take the neighbor's level on a step
    always_comb begin
        n_lvl = r_lvl;
        if (i_ctl.load) begin
            n_lvl.addr_bit = i_load_bit;
            n_lvl.live     = i_ctl.lookup || (LEN_BITS'(IDX) < i_load_len);
        end else if (i_ctl.shift) begin
            n_lvl = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
        end else begin
            r_lvl <= n_lvl;
        end
    end

    assign o_lvl = r_lvl;

endmodule

/* rtl/blp_node_mem.sv */
// Node memory: one write port, one read port with registered read data.
module blp_node_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 65
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write and read; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/binary_trie_longest_prefix_match_unit.sv */
// Top level of the binary trie route store with longest prefix lookup.
//
// Input channel (i_valid/o_ready): one beat is either a lookup of i_address
// (i_mode = 0) or an insert of a route (i_mode = 1) with i_prefix_len low-order
// bits of i_address, i_next_hop and i_out_port. Output channel (o_valid/i_ready):
// exactly one result beat per input beat, in order: o_found, o_hop_out and
// o_port_out for a lookup, o_store_full for an insert dropped for lack of nodes.
// One item is worked on at a time. The walk steps one trie level per cycle
// through the node memory's single read port, with a row of level cells
// presenting the address bit of the current level. A lookup walks at most
// ADDR_BITS levels (32 by default); an insert walks down its existing path
// and then adds one node per level left in its prefix (a dropped one stops
// where its existing path ends), and an insert of length zero does not walk.
// The next item is accepted in the cycle after
// the result is loaded into the output register, even while that beat still
// waits; if the receiver stalls with a beat pending, the finished item waits
// in its final state. Reset empties the store at once (root links cleared,
// one node in use); no clearing pass is run.
module binary_trie_longest_prefix_match_unit #(
    parameter int NODE_COUNT = 4096,
    parameter int ADDR_BITS  = 32,
    parameter int PORT_BITS  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_mode,
    input  logic [ADDR_BITS-1:0]                 i_address,
    input  logic [blp_pkg::LEN_FIELD_BITS-1:0]   i_prefix_len,
    input  logic [blp_pkg::HOP_BITS-1:0]         i_next_hop,
    input  logic [blp_pkg::PORT_FIELD_BITS-1:0]  i_out_port,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_found,
    output logic [blp_pkg::HOP_BITS-1:0]         o_hop_out,
    output logic [blp_pkg::PORT_FIELD_BITS-1:0]  o_port_out,
    output logic                                 o_store_full
);
    import blp_pkg::*;

    localparam int IW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam int LW = $clog2(ADDR_BITS + 1);
    localparam int XW = (CW > LW) ? CW : LW;
    localparam int PB = (PORT_BITS < PORT_FIELD_BITS) ? PORT_BITS : PORT_FIELD_BITS;

    typedef struct packed {
        logic [IW-1:0]       link1;
        logic [IW-1:0]       link0;
        logic                valid;
        logic [HOP_BITS-1:0] hop;
        logic [PB-1:0]       port;
    } t_node;

    localparam int DW = $bits(t_node);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_ALLOC, S_DONE} t_state;

    // Control registers
    t_state               r_state, n_state;
    logic [CW-1:0]        r_free, n_free;
    logic [IW-1:0]        r_root_l0, n_root_l0;
    logic [IW-1:0]        r_root_l1, n_root_l1;
    logic                 r_out_valid, n_out_valid;

    // Item and walk registers
    logic                 r_mode, n_mode;
    logic [LW-1:0]        r_len, n_len;
    logic [LW-1:0]        r_depth, n_depth;
    logic [IW-1:0]        r_node, n_node;
    logic [HOP_BITS-1:0]  r_hop_in, n_hop_in;
    logic [PB-1:0]        r_port_in, n_port_in;
    logic                 r_found, n_found;
    logic [HOP_BITS-1:0]  r_hop, n_hop;
    logic [PB-1:0]        r_port, n_port;
    logic                 r_full, n_full;

    // Output beat registers
    logic                 r_out_found, n_out_found;
    logic [HOP_BITS-1:0]  r_out_hop, n_out_hop;
    logic [PB-1:0]        r_out_port, n_out_port;
    logic                 r_out_full, n_out_full;

    // Datapath signals
    logic [LW-1:0]        w_len;
    t_lvl_ctl             w_ctl;
    t_lvl                 w_lvl [ADDR_BITS+1];
    logic                 w_bit;
    logic                 w_live;
    logic [DW-1:0]        w_rd_data;
    t_node                w_cur;
    t_node                w_upd;
    logic [IW-1:0]        w_child;
    logic [LW-1:0]        w_needed;
    logic [CW-1:0]        w_room;
    logic                 w_no_room;
    logic                 w_wr_en;
    logic [IW-1:0]        w_wr_addr;
    t_node                w_wr_data;
    logic                 w_rd_en;

    // Saturate the prefix length to the address width
    always_comb begin
        if (int'(i_prefix_len) > ADDR_BITS) begin
            w_len = LW'(ADDR_BITS);
        end else begin
            w_len = LW'(i_prefix_len);
        end
    end

    // Row of level cells; level 0 of the walk sits in the first cell
    assign w_lvl[ADDR_BITS] = '0;
    for (genvar gi = 0; gi < ADDR_BITS; gi++) begin : g_lvl
        blp_level_cell #(
            .IDX      (gi),
            .LEN_BITS (LW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_load_bit (i_address[gi]),
            .i_load_len (w_len),
            .i_next     (w_lvl[gi+1]),
            .o_lvl      (w_lvl[gi])
        );
    end

    assign w_bit  = w_lvl[0].addr_bit;
    assign w_live = w_lvl[0].live;

    // Node memory; the root lives in flip-flops so reset clears it at once
    blp_node_mem #(
        .DEPTH (NODE_COUNT),
        .AW    (IW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_child),
        .o_rd_data (w_rd_data)
    );

    // Select the entry of the node the walk stands on
    always_comb begin
        if (r_node == '0) begin
            w_cur       = '0;
            w_cur.link0 = r_root_l0;
            w_cur.link1 = r_root_l1;
        end else begin
            w_cur = t_node'(w_rd_data);
        end
    end

    assign w_child   = w_bit ? w_cur.link1 : w_cur.link0;
    assign w_needed  = r_len - r_depth;
    assign w_room    = CW'(NODE_COUNT) - r_free;
    assign w_no_room = XW'(w_needed) > XW'(w_room);

    assign o_ready = (r_state == S_IDLE);

    // Walk sequencer
    always_comb begin
        n_state     = r_state;
        n_free      = r_free;
        n_root_l0   = r_root_l0;
        n_root_l1   = r_root_l1;
        n_out_valid = r_out_valid;
        n_mode      = r_mode;
        n_len       = r_len;
        n_depth     = r_depth;
        n_node      = r_node;
        n_hop_in    = r_hop_in;
        n_port_in   = r_port_in;
        n_found     = r_found;
        n_hop       = r_hop;
        n_port      = r_port;
        n_full      = r_full;
        n_out_found = r_out_found;
        n_out_hop   = r_out_hop;
        n_out_port  = r_out_port;
        n_out_full  = r_out_full;
        w_ctl       = '0;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_node;
        w_wr_data   = '0;
        w_upd       = w_cur;

        // Drop the output beat once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode     = i_mode;
                    n_len      = w_len;
                    n_hop_in   = i_next_hop;
                    n_port_in  = PB'(i_out_port);
                    n_depth    = '0;
                    n_node     = '0;
                    n_found    = 1'b0;
                    n_hop      = '0;
                    n_port     = '0;
                    n_full     = 1'b0;
                    w_ctl.load   = 1'b1;
                    w_ctl.lookup = (i_mode == MODE_LOOKUP);
                    if (i_mode == MODE_INSERT && w_len == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // Record a route met on the lookup path
                if (r_mode == MODE_LOOKUP && r_node != '0 && w_cur.valid) begin
                    n_found = 1'b1;
                    n_hop   = w_cur.hop;
                    n_port  = w_cur.port;
                end
                if (w_live && w_child != '0) begin
                    // Advance one level
                    w_rd_en     = 1'b1;
                    n_node      = w_child;
                    n_depth     = r_depth + LW'(1);
                    w_ctl.shift = 1'b1;
                end else if (r_mode == MODE_LOOKUP) begin
                    n_state = S_DONE;
                end else if (w_no_room) begin
                    n_full  = 1'b1;
                    n_state = S_DONE;
                end else if (!w_live) begin
                    // Path exists: overwrite the route on the node reached
                    w_wr_en         = 1'b1;
                    w_wr_addr       = r_node;
                    w_wr_data       = w_cur;
                    w_wr_data.valid = 1'b1;
                    w_wr_data.hop   = r_hop_in;
                    w_wr_data.port  = r_port_in;
                    n_state         = S_DONE;
                end else begin
                    // Hook the first new node below the last existing one
                    if (w_bit) begin
                        w_upd.link1 = IW'(r_free);
                    end else begin
                        w_upd.link0 = IW'(r_free);
                    end
                    if (r_node == '0) begin
                        n_root_l0 = w_upd.link0;
                        n_root_l1 = w_upd.link1;
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_node;
                        w_wr_data = w_upd;
                    end
                    w_ctl.shift = 1'b1;
                    n_state     = S_ALLOC;
                end
            end
            S_ALLOC: begin
                // Write one fresh node per cycle; the last one takes the route
                w_wr_en     = 1'b1;
                w_wr_addr   = IW'(r_free);
                n_free      = r_free + CW'(1);
                w_ctl.shift = 1'b1;
                if (w_live) begin
                    if (w_bit) begin
                        w_wr_data.link1 = IW'(r_free + CW'(1));
                    end else begin
                        w_wr_data.link0 = IW'(r_free + CW'(1));
                    end
                end else begin
                    w_wr_data.valid = 1'b1;
                    w_wr_data.hop   = r_hop_in;
                    w_wr_data.port  = r_port_in;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the result until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_hop   = r_hop;
                    n_out_port  = r_port;
                    n_out_full  = r_full;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= CW'(1);
            r_root_l0   <= '0;
            r_root_l1   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_root_l0   <= n_root_l0;
            r_root_l1   <= n_root_l1;
            r_out_valid <= n_out_valid;
        end
        r_mode      <= n_mode;
        r_len       <= n_len;
        r_depth     <= n_depth;
        r_node      <= n_node;
        r_hop_in    <= n_hop_in;
        r_port_in   <= n_port_in;
        r_found     <= n_found;
        r_hop       <= n_hop;
        r_port      <= n_port;
        r_full      <= n_full;
        r_out_found <= n_out_found;
        r_out_hop   <= n_out_hop;
        r_out_port  <= n_out_port;
        r_out_full  <= n_out_full;
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_hop_out    = r_out_hop;
    assign o_port_out   = PORT_FIELD_BITS'(r_out_port);
    assign o_store_full = r_out_full;

endmodule
